// ----- rtl/core/pse_pkg.sv -----
// Package for the postfix stack evaluator: field widths, action and status
// codes, and the command type that steers the stack cells.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package pse_pkg;

    localparam int ACTION_W = 3;
    localparam int NUMBER_W = 32;
    localparam int TOP_W    = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_PUSH  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SUB   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_MUL   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVER  = 2'd2;

    // Width of one multiplier digit taken per cycle.
    localparam int MUL_DIGIT_W = 16;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_PUSH = 2'd1,
        CELL_POP  = 2'd2
    } cell_cmd_t;

endpackage : pse_pkg

`default_nettype wire

// ----- rtl/core/pse_token_if.sv -----
// Handshake interface for the token channel of the postfix stack evaluator.
// Depends on pse_pkg for the field widths.
`default_nettype none

interface pse_token_if;
    import pse_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic signed [NUMBER_W-1:0] number;

    modport source (output valid, output action, output number, input ready);
    modport sink   (input valid, input action, input number, output ready);

endinterface : pse_token_if

`default_nettype wire

// ----- rtl/core/pse_result_if.sv -----
// Handshake interface for the result channel of the postfix stack evaluator.
// Depends on pse_pkg for the field widths.
`default_nettype none

interface pse_result_if;
    import pse_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [TOP_W-1:0] top_value;
    logic [COUNT_W-1:0]      stack_count;
    logic [STATUS_W-1:0]     status;

    modport source (output valid, output top_value, output stack_count, output status,
                    input ready);
    modport sink   (input valid, input top_value, input stack_count, input status,
                    output ready);

endinterface : pse_result_if

`default_nettype wire

// ----- rtl/core/postfix_stack_evaluator.sv -----
// Postfix stack evaluator: top level, stack cell chain and token control.
// Depends on pse_pkg, pse_token_if, pse_result_if, pse_cell and pse_mult.
//
// Each word on the token channel is one parsed token: push number, add,
// subtract, multiply or clear. Operators pop two values and push (second
// popped) op (first popped), wrapping at DATA_WIDTH bits. Every token yields
// one word on the result channel: the new top (0 when empty), the number of
// values held and a status (ok, underflow, overflow). Failed tokens leave the
// stack unchanged; unused action codes are ignored with status ok.
// The stack is a chain of STACK_DEPTH cells with cell 0 on top; a push or a
// pop moves every cell one place in the same cycle.
// Push, add, subtract, clear and failed tokens load the result register at
// the accepting edge, so a new token can be taken every cycle while the
// receiver keeps up. A multiply runs in the digit-serial multiplier and
// writes back when it is done; its result word is loaded at write-back and
// the next token is taken only after that.
// The token channel is held off while the result register is full and not
// being taken, so a stalled receiver stalls the sender without loss.
// Reset empties the stack and the result register; cell contents are kept.
`default_nettype none

module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input wire logic    clk,
    input wire logic    rst_n,
    pse_token_if.sink   token,
    pse_result_if.source result
);
    import pse_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_MUL  = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]         count_reg, count_next;
    logic                  out_valid_reg;
    logic [TOP_W-1:0]      out_top_reg;
    logic [COUNT_W-1:0]    out_count_reg;
    logic [STATUS_W-1:0]   out_status_reg;

    logic [DATA_WIDTH-1:0] cell_value [STACK_DEPTH];
    logic [DATA_WIDTH-1:0] cell0_bottom;
    logic [DATA_WIDTH-1:0] widened;
    logic [DATA_WIDTH-1:0] alu_result;
    logic [DATA_WIDTH-1:0] top_next;
    logic [DATA_WIDTH-1:0] top_out;
    logic [63:0]           number_ext;
    logic [63:0]           top_ext;
    logic [63:0]           count_ext;
    logic [STATUS_W-1:0]   status_next;
    cell_cmd_t             cmd;
    logic                  mul_start;
    logic                  mul_done;
    logic [DATA_WIDTH-1:0] mul_product;
    logic                  in_ready;
    logic                  accept;
    logic                  load_out;
    logic                  have_two;
    logic                  full;

    // Sign-extend the 32-bit number, then keep DATA_WIDTH bits of it.
    assign number_ext = 64'(token.number);
    assign widened    = number_ext[DATA_WIDTH-1:0];

    assign alu_result = (token.action == ACT_SUB) ? (cell_value[1] - cell_value[0])
                                                   : (cell_value[1] + cell_value[0]);

    assign have_two = (count_reg >= CW'(2));
    assign full     = (count_reg == CW'(STACK_DEPTH));
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || result.ready);
    assign accept   = token.valid && in_ready;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        status_next  = STATUS_OK;
        top_next     = cell_value[0];
        cmd          = CELL_HOLD;
        cell0_bottom = alu_result;
        mul_start    = 1'b0;
        load_out     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    load_out = 1'b1;
                    unique case (token.action) inside
                        ACT_PUSH:
                        begin
                            if (full)
                            begin
                                status_next = STATUS_OVER;
                            end
                            else
                            begin
                                cmd        = CELL_PUSH;
                                count_next = count_reg + 1'b1;
                                top_next   = widened;
                            end
                        end
                        ACT_ADD, ACT_SUB:
                        begin
                            if (!have_two)
                            begin
                                status_next = STATUS_UNDER;
                            end
                            else
                            begin
                                cmd        = CELL_POP;
                                count_next = count_reg - 1'b1;
                                top_next   = alu_result;
                            end
                        end
                        ACT_MUL:
                        begin
                            if (!have_two)
                            begin
                                status_next = STATUS_UNDER;
                            end
                            else
                            begin
                                load_out   = 1'b0;
                                mul_start  = 1'b1;
                                state_next = ST_MUL;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                cell0_bottom = mul_product;
                if (mul_done)
                begin
                    cmd        = CELL_POP;
                    count_next = count_reg - 1'b1;
                    top_next   = mul_product;
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign top_out   = (count_next == '0) ? '0 : top_next;
    assign top_ext   = 64'(top_out);
    assign count_ext = 64'(count_next);

    // Stack cell chain; cell 0 is the top of the stack.
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] above;
        logic [DATA_WIDTH-1:0] below;
        if (i == 0)
        begin : g_top
            assign above = widened;
            assign below = cell0_bottom;
        end
        else if (i == STACK_DEPTH - 1)
        begin : g_last
            assign above = cell_value[i-1];
            assign below = '0;
        end
        else
        begin : g_mid
            assign above = cell_value[i-1];
            assign below = cell_value[i+1];
        end
        pse_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .from_top    (above),
            .from_bottom (below),
            .value       (cell_value[i])
        );
    end

    pse_mult #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (cell_value[1]),
        .b       (cell_value[0]),
        .done    (mul_done),
        .product (mul_product)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_top_reg    <= top_ext[TOP_W-1:0];
            out_count_reg  <= count_ext[COUNT_W-1:0];
            out_status_reg <= status_next;
        end
    end

    assign token.ready        = in_ready;
    assign result.valid       = out_valid_reg;
    assign result.top_value   = out_top_reg;
    assign result.stack_count = out_count_reg;
    assign result.status      = out_status_reg;

endmodule : postfix_stack_evaluator

`default_nettype wire

// ----- rtl/core/pse_cell.sv -----
// One stack cell: holds a single operand and moves it one place deeper on a
// push or one place toward the top on a pop. Depends on pse_pkg.
`default_nettype none

module pse_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire pse_pkg::cell_cmd_t    cmd,
    input  wire logic [DATA_WIDTH-1:0] from_top,
    input  wire logic [DATA_WIDTH-1:0] from_bottom,
    output logic      [DATA_WIDTH-1:0] value
);
    import pse_pkg::*;

    logic [DATA_WIDTH-1:0] value_reg;

    always_ff @(posedge clk)
    begin
        case (cmd)
            CELL_PUSH: value_reg <= from_top;
            CELL_POP:  value_reg <= from_bottom;
            default:   value_reg <= value_reg;
        endcase
    end

    assign value = value_reg;

endmodule : pse_cell

`default_nettype wire

// ----- rtl/core/pse_mult.sv -----
// Digit-serial multiplier: low DATA_WIDTH bits of a*b, one digit of b per cycle.
// Depends on pse_pkg for the digit width.
`default_nettype none

module pse_mult #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DATA_WIDTH-1:0] a,
    input  wire logic [DATA_WIDTH-1:0] b,
    output logic                       done,
    output logic      [DATA_WIDTH-1:0] product
);
    import pse_pkg::*;

    localparam int DIGIT_W = (DATA_WIDTH < MUL_DIGIT_W) ? DATA_WIDTH : MUL_DIGIT_W;
    localparam int DIGITS  = (DATA_WIDTH + DIGIT_W - 1) / DIGIT_W;
    localparam int CNT_W   = $clog2(DIGITS + 1);

    logic [DATA_WIDTH-1:0]         a_reg;
    logic [DATA_WIDTH-1:0]         b_reg;
    logic [DATA_WIDTH-1:0]         acc_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          done_reg;
    logic [DATA_WIDTH+DIGIT_W-1:0] partial;

    // Weight of the current digit is already folded into a_reg by shifting.
    assign partial = a_reg * b_reg[DIGIT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(DIGITS);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            a_reg   <= a_reg << DIGIT_W;
            b_reg   <= b_reg >> DIGIT_W;
            acc_reg <= acc_reg + partial[DATA_WIDTH-1:0];
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule : pse_mult

`default_nettype wire
